/* hdl/ffcu_pkg.sv */
// Package for the free-fly camera update unit: codes, fixed-point constants,
// the sequencer state type, the CORDIC arctangent table and saturation.
// Depends on nothing.
package ffcu_pkg;

   localparam int FRAC_BITS           = 16;
   localparam int CORDIC_ITER_DEFAULT = 16;

   // Event codes
   localparam logic [1:0] ACT_MOVE   = 2'd0;
   localparam logic [1:0] ACT_LOOK   = 2'd1;
   localparam logic [1:0] ACT_SCROLL = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   // Move directions
   localparam logic [1:0] DIR_FWD   = 2'd0;
   localparam logic [1:0] DIR_BACK  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_POS    = 3'd0;
   localparam logic [2:0] KIND_FWD    = 3'd1;
   localparam logic [2:0] KIND_RIGHT  = 3'd2;
   localparam logic [2:0] KIND_UP     = 3'd3;
   localparam logic [2:0] KIND_ANGLES = 3'd4;

   // Register indexes
   localparam logic [2:0] CSR_SPEED = 3'd0;
   localparam logic [2:0] CSR_SENS  = 3'd1;
   localparam logic [2:0] CSR_UPX   = 3'd2;
   localparam logic [2:0] CSR_UPY   = 3'd3;
   localparam logic [2:0] CSR_UPZ   = 3'd4;

   localparam logic [31:0] SPEED_RESET = 32'd163840;
   localparam logic [15:0] SENS_RESET  = 16'd6554;

   localparam logic signed [31:0] ONE_Q      = 32'(1 << FRAC_BITS);
   localparam logic signed [31:0] YAW_RESET  = 32'(-90 * (1 << FRAC_BITS));
   localparam logic signed [31:0] ZOOM_MAX   = 32'(45 * (1 << FRAC_BITS));
   localparam logic signed [31:0] PITCH_MAX  = 32'(89 * (1 << FRAC_BITS));
   localparam logic signed [31:0] PITCH_MIN  = 32'(-89 * (1 << FRAC_BITS));
   localparam logic signed [31:0] DEG_90     = 32'(90 * (1 << FRAC_BITS));
   localparam logic signed [31:0] DEG_180    = 32'(180 * (1 << FRAC_BITS));

   localparam logic signed [35:0] WRAP_HALF   = 36'(180 * (1 << FRAC_BITS));
   localparam logic signed [35:0] WRAP_PERIOD = 36'(360 * (1 << FRAC_BITS));
   localparam logic signed [35:0] WRAP_OFFSET =
      36'(longint'(360) * (longint'(1) << FRAC_BITS) * 256);
   localparam logic [3:0]         WRAP_STEPS  = 4'd8;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [32:0] DEG_TO_RAD  = 33'sd74961321;

   typedef enum logic [4:0] {
      S_IDLE, S_MV_VEL, S_MV_SAT, S_MV_MUL, S_MV_ACC,
      S_LK_MUL, S_LK_ADD, S_LK_WRAP,
      S_CO_INIT, S_CO_Z, S_CO_ITER,
      S_FW_MUL, S_FW_ST,
      S_CR_MUL1, S_CR_MUL2, S_CR_SUB,
      S_SQ_MUL, S_SQ_ACC, S_RT_STEP,
      S_DV_INIT, S_DV_STEP, S_DV_ST,
      S_SCROLL, S_EMIT
   } state_type;

   function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
      logic signed [33:0] v;
      unique case (i)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sh7FFFFFFF)
         r = 32'sh7FFFFFFF;
      else if (v < -68'sh80000000)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

/* hdl/free_fly_camera_update_unit.sv */
// Free-fly camera update unit: top level with one shared multiplier and
// iterative wrap, CORDIC, square-root and division steps under a sequencer.
// Depends on ffcu_pkg.
//
//  Channel   Direction  Handshake          Carries
//  req_*     in         valid / stall      one camera event (move, look, scroll)
//  rsp_*     out        valid / stall      one vector or angle triple per result
//  csr_*     in         write enable only  speed, sensitivity, world up
//
// A look request runs much longer than a move or a scroll request: the three
// 18-step divisions per normalization and the 20-step square root dominate,
// all run through the same step registers.
// Reset is synchronous and restores the registers and the camera state.
// req_stall is high from acceptance until the last result has entered the
// output register; a stalled result holds in that register.
module free_fly_camera_update_unit
   import ffcu_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_move_dir,
   input  logic [23:0]        req_elapsed,
   input  logic signed [23:0] req_offset_x,
   input  logic signed [23:0] req_offset_y,
   input  logic               req_clamp_pitch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_vector_kind,
   output logic signed [31:0] rsp_comp_x,
   output logic signed [31:0] rsp_comp_y,
   output logic signed [31:0] rsp_comp_z,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);

   state_type state_ff, state_in;

   // Configuration
   logic [31:0]        speed_ff;
   logic [15:0]        sens_ff;
   logic signed [17:0] wup_ff [3];

   // Camera state
   logic signed [31:0] yaw_ff, pitch_ff, zoom_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] fwd_ff [3];
   logic signed [31:0] rgt_ff [3];
   logic signed [31:0] up_ff  [3];

   // Latched request
   logic [1:0]         dir_ff;
   logic [23:0]        elapsed_ff;
   logic signed [23:0] ox_ff, oy_ff;
   logic               clamp_ff;

   // Sequencer and working registers
   logic               sel_ff;
   logic [1:0]         idx_ff;
   logic [4:0]         cnt_ff;
   logic [2:0]         ek_ff;
   logic signed [65:0] prod_ff, t1_ff;
   logic signed [31:0] vel_ff;
   logic signed [35:0] ang_ff;
   logic               neg_ff;
   logic signed [33:0] crd_x_ff, crd_y_ff, crd_z_ff;
   logic signed [33:0] sin_yaw_ff, cos_yaw_ff, sin_pitch_ff, cos_pitch_ff;
   logic signed [23:0] cr_ff [3];
   logic [39:0]        sum_ff, sq_v_ff, sq_r_ff, sq_bit_ff, rem_ff;
   logic [20:0]        len_ff;
   logic [17:0]        quo_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_kind_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic               rsp_last_ff;

   // Combinational helpers
   logic               req_take, emit_load, emit_last;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_in;
   logic [1:0]         cj, ck;
   logic signed [31:0] cross_a_j, cross_a_k, cross_b_j, cross_b_k;
   logic signed [31:0] mvec;
   logic signed [31:0] fold_src;
   logic signed [32:0] fold_val;
   logic               fold_neg;
   logic [49:0]        vel_wide;
   logic signed [67:0] pos_sum;
   logic signed [65:0] pos_d;
   logic signed [35:0] look_t, ang_load, wrap_pk, ang_nx;
   logic signed [31:0] wrapped;
   logic signed [33:0] crd_x_nx, crd_y_nx, crd_z_nx, crd_sx, crd_sy;
   logic signed [65:0] cross_diff;
   logic [39:0]        sq_trial, sq_v_nx, sq_r_nx, div_dk;
   logic               div_ge;
   logic [23:0]        cr_abs;
   logic signed [31:0] quo_signed;
   logic signed [35:0] zoom_t;

   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_vector_kind = rsp_kind_ff;
   assign rsp_comp_x = rsp_x_ff;
   assign rsp_comp_y = rsp_y_ff;
   assign rsp_comp_z = rsp_z_ff;
   assign rsp_last   = rsp_last_ff;

   // The one shared multiplier; its product is always registered.
   assign prod_in = mul_a * mul_b;

   // Cross-product component: c[i] = a[j]*b[k] - a[k]*b[j]
   always_comb begin
      unique case (idx_ff)
         2'd0:    begin cj = 2'd1; ck = 2'd2; end
         2'd1:    begin cj = 2'd2; ck = 2'd0; end
         default: begin cj = 2'd0; ck = 2'd1; end
      endcase
      if (sel_ff) begin
         cross_a_j = rgt_ff[cj];
         cross_a_k = rgt_ff[ck];
         cross_b_j = fwd_ff[cj];
         cross_b_k = fwd_ff[ck];
      end else begin
         cross_a_j = fwd_ff[cj];
         cross_a_k = fwd_ff[ck];
         cross_b_j = 32'(wup_ff[cj]);
         cross_b_k = 32'(wup_ff[ck]);
      end
   end

   // Angle fold into [-90, 90] ahead of the CORDIC
   always_comb begin
      fold_src = sel_ff ? pitch_ff : yaw_ff;
      fold_neg = 1'b0;
      fold_val = 33'(fold_src);
      if (fold_src > DEG_90) begin
         fold_val = 33'(DEG_180) - 33'(fold_src);
         fold_neg = 1'b1;
      end else if (fold_src < -DEG_90) begin
         fold_val = -33'(DEG_180) - 33'(fold_src);
         fold_neg = 1'b1;
      end
   end

   assign mvec = (dir_ff == DIR_FWD || dir_ff == DIR_BACK) ? fwd_ff[idx_ff] : rgt_ff[idx_ff];

   // Multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MV_VEL: begin
            mul_a = {1'b0, speed_ff};
            mul_b = {9'b0, elapsed_ff};
         end
         S_MV_MUL: begin
            mul_a = 33'(mvec);
            mul_b = 33'(vel_ff);
         end
         S_LK_MUL: begin
            mul_a = {17'b0, sens_ff};
            mul_b = sel_ff ? 33'(oy_ff) : 33'(ox_ff);
         end
         S_CO_INIT: begin
            mul_a = fold_val;
            mul_b = DEG_TO_RAD;
         end
         S_FW_MUL: begin
            mul_a = (idx_ff == 2'd0) ? cos_yaw_ff[32:0] : sin_yaw_ff[32:0];
            mul_b = cos_pitch_ff[32:0];
         end
         S_CR_MUL1: begin
            mul_a = 33'(cross_a_j);
            mul_b = 33'(cross_b_k);
         end
         S_CR_MUL2: begin
            mul_a = 33'(cross_a_k);
            mul_b = 33'(cross_b_j);
         end
         S_SQ_MUL: begin
            mul_a = 33'(cr_ff[idx_ff]);
            mul_b = 33'(cr_ff[idx_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Datapath step values
   always_comb begin
      vel_wide = 50'(prod_ff >>> (32 - FRAC_BITS));
      pos_d    = prod_ff >>> FRAC_BITS;
      if (dir_ff == DIR_BACK || dir_ff == DIR_LEFT)
         pos_sum = 68'(pos_ff[idx_ff]) - 68'(pos_d);
      else
         pos_sum = 68'(pos_ff[idx_ff]) + 68'(pos_d);

      look_t = (sel_ff ? 36'(pitch_ff) : 36'(yaw_ff))
               + 36'(prod_ff >>> (24 - FRAC_BITS));
      if (sel_ff && clamp_ff) begin
         if (look_t > 36'(PITCH_MAX))
            look_t = 36'(PITCH_MAX);
         else if (look_t < 36'(PITCH_MIN))
            look_t = 36'(PITCH_MIN);
      end
      ang_load = look_t + WRAP_HALF + WRAP_OFFSET;

      wrap_pk = WRAP_PERIOD <<< cnt_ff;
      ang_nx  = (ang_ff >= wrap_pk) ? ang_ff - wrap_pk : ang_ff;
      wrapped = 32'(ang_nx - WRAP_HALF);

      crd_sx = crd_x_ff >>> cnt_ff;
      crd_sy = crd_y_ff >>> cnt_ff;
      if (!crd_z_ff[33]) begin
         crd_x_nx = crd_x_ff - crd_sy;
         crd_y_nx = crd_y_ff + crd_sx;
         crd_z_nx = crd_z_ff - atan_entry(cnt_ff);
      end else begin
         crd_x_nx = crd_x_ff + crd_sy;
         crd_y_nx = crd_y_ff - crd_sx;
         crd_z_nx = crd_z_ff + atan_entry(cnt_ff);
      end

      cross_diff = (t1_ff - prod_ff) >>> FRAC_BITS;

      sq_trial = sq_r_ff + sq_bit_ff;
      if (sq_v_ff >= sq_trial) begin
         sq_v_nx = sq_v_ff - sq_trial;
         sq_r_nx = (sq_r_ff >> 1) + sq_bit_ff;
      end else begin
         sq_v_nx = sq_v_ff;
         sq_r_nx = sq_r_ff >> 1;
      end

      div_dk = 40'(len_ff) << cnt_ff;
      div_ge = rem_ff >= div_dk;
      cr_abs = cr_ff[idx_ff][23] ? 24'(-cr_ff[idx_ff]) : cr_ff[idx_ff];
      quo_signed = cr_ff[idx_ff][23] ? -32'({14'b0, quo_ff}) : 32'({14'b0, quo_ff});

      zoom_t = 36'(zoom_ff) - (36'(oy_ff) <<< (FRAC_BITS - 8));
      if (zoom_t < 36'(ONE_Q))
         zoom_t = 36'(ONE_Q);
      else if (zoom_t > 36'(ZOOM_MAX))
         zoom_t = 36'(ZOOM_MAX);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (req_action)
                  ACT_MOVE:   state_in = S_MV_VEL;
                  ACT_LOOK:   state_in = S_LK_MUL;
                  ACT_SCROLL: state_in = S_SCROLL;
                  ACT_NOP:    state_in = S_IDLE;
               endcase
            end
         end
         S_MV_VEL:  state_in = S_MV_SAT;
         S_MV_SAT:  state_in = S_MV_MUL;
         S_MV_MUL:  state_in = S_MV_ACC;
         S_MV_ACC:  state_in = (idx_ff == 2'd2) ? S_EMIT : S_MV_MUL;
         S_LK_MUL:  state_in = S_LK_ADD;
         S_LK_ADD:  state_in = S_LK_WRAP;
         S_LK_WRAP: begin
            if (cnt_ff == 5'd0)
               state_in = sel_ff ? S_CO_INIT : S_LK_MUL;
         end
         S_CO_INIT: state_in = S_CO_Z;
         S_CO_Z:    state_in = S_CO_ITER;
         S_CO_ITER: begin
            if (cnt_ff == ITER_LAST)
               state_in = sel_ff ? S_FW_MUL : S_CO_INIT;
         end
         S_FW_MUL:  state_in = S_FW_ST;
         S_FW_ST:   state_in = (idx_ff == 2'd0) ? S_FW_MUL : S_CR_MUL1;
         S_CR_MUL1: state_in = S_CR_MUL2;
         S_CR_MUL2: state_in = S_CR_SUB;
         S_CR_SUB:  state_in = (idx_ff == 2'd2) ? S_SQ_MUL : S_CR_MUL1;
         S_SQ_MUL:  state_in = S_SQ_ACC;
         S_SQ_ACC:  state_in = (idx_ff == 2'd2) ? S_RT_STEP : S_SQ_MUL;
         S_RT_STEP: state_in = (cnt_ff == 5'd0) ? S_DV_INIT : S_RT_STEP;
         S_DV_INIT: state_in = S_DV_STEP;
         S_DV_STEP: state_in = (cnt_ff == 5'd0) ? S_DV_ST : S_DV_STEP;
         S_DV_ST: begin
            if (idx_ff != 2'd2)
               state_in = S_DV_INIT;
            else
               state_in = sel_ff ? S_EMIT : S_CR_MUL1;
         end
         S_SCROLL:  state_in = S_EMIT;
         S_EMIT: begin
            if (emit_load && emit_last)
               state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
      emit_last = (ek_ff == KIND_POS) || (ek_ff == KIND_ANGLES);
   end

   // Control, configuration and camera state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= SPEED_RESET;
         sens_ff      <= SENS_RESET;
         wup_ff[0]    <= '0;
         wup_ff[1]    <= 18'(ONE_Q);
         wup_ff[2]    <= '0;
         yaw_ff       <= YAW_RESET;
         pitch_ff     <= '0;
         zoom_ff      <= ZOOM_MAX;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
         end
         fwd_ff[0] <= '0;
         fwd_ff[1] <= '0;
         fwd_ff[2] <= -ONE_Q;
         rgt_ff[0] <= ONE_Q;
         rgt_ff[1] <= '0;
         rgt_ff[2] <= '0;
         up_ff[0]  <= '0;
         up_ff[1]  <= ONE_Q;
         up_ff[2]  <= '0;
      end else begin
         state_ff <= state_in;
         if (emit_load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;

         if (csr_write) begin
            unique case (csr_index)
               CSR_SPEED: speed_ff  <= csr_wdata;
               CSR_SENS:  sens_ff   <= csr_wdata[15:0];
               CSR_UPX:   wup_ff[0] <= csr_wdata[17:0];
               CSR_UPY:   wup_ff[1] <= csr_wdata[17:0];
               CSR_UPZ:   wup_ff[2] <= csr_wdata[17:0];
               default:   ;
            endcase
         end

         unique case (state_ff)
            S_MV_ACC:  pos_ff[idx_ff] <= sat32(pos_sum);
            S_LK_WRAP: begin
               if (cnt_ff == 5'd0) begin
                  if (sel_ff)
                     pitch_ff <= wrapped;
                  else
                     yaw_ff <= wrapped;
               end
            end
            S_FW_ST: begin
               if (idx_ff == 2'd0) begin
                  fwd_ff[0] <= sat32(68'(prod_ff >>> (60 - FRAC_BITS)));
                  fwd_ff[1] <= sat32(68'(sin_pitch_ff >>> (30 - FRAC_BITS)));
               end else begin
                  fwd_ff[2] <= sat32(68'(prod_ff >>> (60 - FRAC_BITS)));
               end
            end
            S_DV_ST: begin
               if (sel_ff)
                  up_ff[idx_ff] <= (len_ff == '0) ? '0 : quo_signed;
               else
                  rgt_ff[idx_ff] <= (len_ff == '0) ? '0 : quo_signed;
            end
            S_SCROLL:  zoom_ff <= 32'(zoom_t);
            default:   ;
         endcase
      end
   end

   // Working registers and the output payload
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (emit_load) begin
         rsp_kind_ff <= ek_ff;
         rsp_last_ff <= emit_last;
         unique case (ek_ff)
            KIND_POS: begin
               rsp_x_ff <= pos_ff[0]; rsp_y_ff <= pos_ff[1]; rsp_z_ff <= pos_ff[2];
            end
            KIND_FWD: begin
               rsp_x_ff <= fwd_ff[0]; rsp_y_ff <= fwd_ff[1]; rsp_z_ff <= fwd_ff[2];
            end
            KIND_RIGHT: begin
               rsp_x_ff <= rgt_ff[0]; rsp_y_ff <= rgt_ff[1]; rsp_z_ff <= rgt_ff[2];
            end
            KIND_UP: begin
               rsp_x_ff <= up_ff[0]; rsp_y_ff <= up_ff[1]; rsp_z_ff <= up_ff[2];
            end
            default: begin
               rsp_x_ff <= yaw_ff; rsp_y_ff <= pitch_ff; rsp_z_ff <= zoom_ff;
            end
         endcase
         ek_ff <= ek_ff + 3'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            dir_ff     <= req_move_dir;
            elapsed_ff <= req_elapsed;
            ox_ff      <= req_offset_x;
            oy_ff      <= req_offset_y;
            clamp_ff   <= req_clamp_pitch;
            sel_ff     <= 1'b0;
            idx_ff     <= 2'd0;
            ek_ff      <= (req_action == ACT_MOVE) ? KIND_POS : KIND_ANGLES;
         end
         S_MV_SAT: begin
            vel_ff <= (vel_wide > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(vel_wide);
            idx_ff <= 2'd0;
         end
         S_MV_ACC:  idx_ff <= idx_ff + 2'd1;
         S_LK_ADD: begin
            ang_ff <= ang_load;
            cnt_ff <= 5'(WRAP_STEPS);
         end
         S_LK_WRAP: begin
            ang_ff <= ang_nx;
            if (cnt_ff == 5'd0)
               sel_ff <= !sel_ff;
            else
               cnt_ff <= cnt_ff - 5'd1;
         end
         S_CO_INIT: neg_ff <= fold_neg;
         S_CO_Z: begin
            crd_z_ff <= 34'(prod_ff >>> (FRAC_BITS + 2));
            crd_x_ff <= CORDIC_GAIN;
            crd_y_ff <= '0;
            cnt_ff   <= 5'd0;
         end
         S_CO_ITER: begin
            crd_x_ff <= crd_x_nx;
            crd_y_ff <= crd_y_nx;
            crd_z_ff <= crd_z_nx;
            cnt_ff   <= cnt_ff + 5'd1;
            if (cnt_ff == ITER_LAST) begin
               sel_ff <= !sel_ff;
               idx_ff <= 2'd0;
               if (sel_ff) begin
                  sin_pitch_ff <= crd_y_nx;
                  cos_pitch_ff <= neg_ff ? -crd_x_nx : crd_x_nx;
               end else begin
                  sin_yaw_ff <= crd_y_nx;
                  cos_yaw_ff <= neg_ff ? -crd_x_nx : crd_x_nx;
               end
            end
         end
         S_FW_ST: begin
            // After the z component the cross products start on forward x up.
            idx_ff <= (idx_ff == 2'd0) ? 2'd2 : 2'd0;
            sel_ff <= 1'b0;
         end
         S_CR_MUL2: t1_ff <= prod_ff;
         S_CR_SUB: begin
            cr_ff[idx_ff] <= 24'(cross_diff);
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            sum_ff <= '0;
         end
         S_SQ_ACC: begin
            sum_ff <= sum_ff + prod_ff[39:0];
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               sq_v_ff   <= sum_ff + prod_ff[39:0];
               sq_r_ff   <= '0;
               sq_bit_ff <= 40'd1 << 38;
               cnt_ff    <= 5'd19;
            end
         end
         S_RT_STEP: begin
            sq_v_ff   <= sq_v_nx;
            sq_r_ff   <= sq_r_nx;
            sq_bit_ff <= sq_bit_ff >> 2;
            cnt_ff    <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0)
               len_ff <= sq_r_nx[20:0];
         end
         S_DV_INIT: begin
            rem_ff <= {cr_abs, 16'b0};
            quo_ff <= '0;
            cnt_ff <= 5'd17;
         end
         S_DV_STEP: begin
            if (div_ge)
               rem_ff <= rem_ff - div_dk;
            quo_ff[cnt_ff] <= div_ge;
            cnt_ff <= cnt_ff - 5'd1;
         end
         S_DV_ST: begin
            if (idx_ff == 2'd2) begin
               idx_ff <= 2'd0;
               sel_ff <= 1'b1;
               ek_ff  <= KIND_FWD;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

endmodule

/* bench/free_fly_camera_update_unit_tb.sv */
// Self-checking bench for the free-fly camera update unit: random and directed
// camera events, with a fixed-point camera predictor held in a scoreboard class.
// Depends on ffcu_pkg and free_fly_camera_update_unit.
`timescale 1ns / 1ps

module free_fly_camera_update_unit_tb
   import ffcu_pkg::*;
();

   typedef struct {
      logic [1:0]         action;
      logic [1:0]         move_dir;
      logic [23:0]        elapsed;
      logic signed [23:0] offset_x;
      logic signed [23:0] offset_y;
      logic               clamp_pitch;
   } request_type;

   typedef struct {
      logic [2:0]         kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
   } vector_type;

   // Camera predictor plus the queue of vectors it still expects to see.
   class camera_scoreboard;
      localparam longint ONE = 64'sd1 << FRAC_BITS;
      localparam longint GAIN_Q30 = 64'sd652032874;
      localparam longint RAD_PER_DEG_Q32 = 64'sd74961321;

      longint  arctan_q30[30] = '{
         843314856, 497837829, 263043836, 133525158, 67021686,
         33543515, 16775850, 8388437, 4194282, 2097149,
         1048575, 524287, 262143, 131071, 65535,
         32767, 16383, 8191, 4095, 2047,
         1023, 511, 255, 127, 63,
         31, 15, 7, 3, 1};

      longint  speed, sensitivity;
      longint  world_up[3];
      longint  yaw, pitch, zoom;
      longint  position[3], forward[3], right[3], up[3];
      vector_type pending_vectors[$];
      int      failures, checked;

      function new();
         speed = SPEED_RESET;
         sensitivity = SENS_RESET;
         world_up = '{0, ONE, 0};
         yaw = -90 * ONE;
         pitch = 0;
         zoom = 45 * ONE;
         position = '{0, 0, 0};
         forward = '{0, 0, -ONE};
         right = '{ONE, 0, 0};
         up = '{0, ONE, 0};
         failures = 0;
         checked = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint wrap_angle(longint a);
         longint r;
         r = (a + 180 * ONE) % (360 * ONE);
         if (r < 0) r += 360 * ONE;
         return r - 180 * ONE;
      endfunction

      // CORDIC rotation; angles beyond a right angle are folded back first.
      function void sin_cos(input longint a, output longint s, output longint c);
         longint x, y, z, nx;
         bit     flip;
         flip = 0;
         x = GAIN_Q30;
         y = 0;
         if (a > 90 * ONE) begin
            a = 180 * ONE - a;
            flip = 1;
         end else if (a < -90 * ONE) begin
            a = -180 * ONE - a;
            flip = 1;
         end
         z = (a * RAD_PER_DEG_Q32) >>> (FRAC_BITS + 2);
         for (int i = 0; i < CORDIC_ITER_DEFAULT; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= arctan_q30[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += arctan_q30[i];
            end
            x = nx;
         end
         s = y;
         c = flip ? -x : x;
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000000000000000;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Unit cross product; a zero-length cross gives the zero vector.
      function void unit_cross(input longint a[3], input longint b[3], output longint r[3]);
         longint          c[3];
         longint unsigned sum, len;
         c[0] = (a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS;
         c[1] = (a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS;
         c[2] = (a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS;
         sum = 0;
         for (int i = 0; i < 3; i++) sum += c[i] * c[i];
         len = root(sum);
         for (int i = 0; i < 3; i++)
            r[i] = (len == 0) ? 0 : clamp32((c[i] * ONE) / longint'(len));
      endfunction

      function void push(logic [2:0] kind, longint x, longint y, longint z, logic last);
         vector_type v;
         v.kind = kind;
         v.x = clamp32(x);
         v.y = clamp32(y);
         v.z = clamp32(z);
         v.last = last;
         pending_vectors.push_back(v);
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] data);
         case (index)
            CSR_SPEED: speed = data;
            CSR_SENS:  sensitivity = data[15:0];
            CSR_UPX:   world_up[0] = longint'(signed'(data[17:0]));
            CSR_UPY:   world_up[1] = longint'(signed'(data[17:0]));
            CSR_UPZ:   world_up[2] = longint'(signed'(data[17:0]));
            default: ;
         endcase
      endfunction

      function void note_request(request_type q);
         longint unsigned v;
         longint          vel, d, sy, cy, sp, cp;
         case (q.action)
            ACT_MOVE: begin
               v = (64'(speed) * 64'(q.elapsed)) >> (32 - FRAC_BITS);
               vel = (v > 64'd2147483647) ? 64'sd2147483647 : longint'(v);
               for (int i = 0; i < 3; i++) begin
                  d = (((q.move_dir == DIR_FWD) || (q.move_dir == DIR_BACK)) ?
                       forward[i] : right[i]) * vel;
                  d = d >>> FRAC_BITS;
                  if ((q.move_dir == DIR_BACK) || (q.move_dir == DIR_LEFT)) d = -d;
                  position[i] = clamp32(position[i] + d);
               end
               push(KIND_POS, position[0], position[1], position[2], 1'b1);
            end
            ACT_LOOK: begin
               yaw += (sensitivity * longint'(q.offset_x)) >>> (24 - FRAC_BITS);
               pitch += (sensitivity * longint'(q.offset_y)) >>> (24 - FRAC_BITS);
               if (q.clamp_pitch) begin
                  if (pitch > 89 * ONE) pitch = 89 * ONE;
                  if (pitch < -89 * ONE) pitch = -89 * ONE;
               end
               yaw = wrap_angle(yaw);
               pitch = wrap_angle(pitch);
               sin_cos(yaw, sy, cy);
               sin_cos(pitch, sp, cp);
               forward[0] = clamp32((cy * cp) >>> (60 - FRAC_BITS));
               forward[1] = clamp32(sp >>> (30 - FRAC_BITS));
               forward[2] = clamp32((sy * cp) >>> (60 - FRAC_BITS));
               unit_cross(forward, world_up, right);
               unit_cross(right, forward, up);
               push(KIND_FWD, forward[0], forward[1], forward[2], 1'b0);
               push(KIND_RIGHT, right[0], right[1], right[2], 1'b0);
               push(KIND_UP, up[0], up[1], up[2], 1'b0);
               push(KIND_ANGLES, yaw, pitch, zoom, 1'b1);
            end
            ACT_SCROLL: begin
               zoom -= longint'(q.offset_y) * (64'sd1 << (FRAC_BITS - 8));
               if (zoom < ONE) zoom = ONE;
               if (zoom > 45 * ONE) zoom = 45 * ONE;
               push(KIND_ANGLES, yaw, pitch, zoom, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(vector_type got);
         vector_type want;
         checked++;
         if (pending_vectors.size() == 0) begin
            $error("unexpected result: kind %0d (%0d, %0d, %0d)", got.kind, got.x, got.y,
                   got.z);
            failures++;
            return;
         end
         want = pending_vectors.pop_front();
         if (got.kind !== want.kind) begin
            $error("vector_kind: expected %0d, got %0d", want.kind, got.kind);
            failures++;
         end
         if (got.x !== want.x) begin
            $error("comp_x: expected %0d, got %0d", want.x, got.x);
            failures++;
         end
         if (got.y !== want.y) begin
            $error("comp_y: expected %0d, got %0d", want.y, got.y);
            failures++;
         end
         if (got.z !== want.z) begin
            $error("comp_z: expected %0d, got %0d", want.z, got.z);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   // SETTLE_CYCLES covers a whole look request with margin.
   localparam int SETTLE_CYCLES = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = ACT_NOP;
   logic [1:0]         req_move_dir = DIR_FWD;
   logic [23:0]        req_elapsed = '0;
   logic signed [23:0] req_offset_x = '0;
   logic signed [23:0] req_offset_y = '0;
   logic               req_clamp_pitch = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_vector_kind;
   logic signed [31:0] rsp_comp_x;
   logic signed [31:0] rsp_comp_y;
   logic signed [31:0] rsp_comp_z;
   logic               rsp_last;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = CSR_SPEED;
   logic [31:0]        csr_wdata = '0;

   camera_scoreboard camera;
   int               requests_taken = 0;
   bit               quiet = 0;        // no idling on either side in the last part
   bit               long_hold = 0;    // asks the receiver for one long hold-off

   always #5 clock = ~clock;

   free_fly_camera_update_unit DUT (.*);

   // Results are checked at the edge where they are taken, using the values
   // present just before that edge.
   always @(posedge clock) begin
      vector_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_vector_kind;
         got.x = rsp_comp_x;
         got.y = rsp_comp_y;
         got.z = rsp_comp_z;
         got.last = rsp_last;
         camera.check_result(got);
      end
   end

   // Receiver: random stall bursts, free stretches, and one long hold-off on
   // request so that the output register fills and the block holds off input.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (900) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17) - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20) - 1) @(posedge clock);
         end
      end
   end

   // Hands one request to the block, sometimes after an idle burst, and returns
   // at the edge where it was taken.
   task automatic send_request(request_type q);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= q.action;
      req_move_dir <= q.move_dir;
      req_elapsed <= q.elapsed;
      req_offset_x <= q.offset_x;
      req_offset_y <= q.offset_y;
      req_clamp_pitch <= q.clamp_pitch;
      do @(posedge clock); while (req_stall);
      camera.note_request(q);
      requests_taken++;
   endtask

   function automatic request_type make_request(logic [1:0] action, logic [1:0] dir,
                                                logic [23:0] elapsed, logic [23:0] ox,
                                                logic [23:0] oy, logic clamp);
      request_type q;
      q.action = action;
      q.move_dir = dir;
      q.elapsed = elapsed;
      q.offset_x = ox;
      q.offset_y = oy;
      q.clamp_pitch = clamp;
      return q;
   endfunction

   // Mostly moderate values so that the camera wanders sensibly, with a share
   // of fully random fields so that every bit toggles.
   function automatic request_type random_request();
      request_type q;
      int          pick;
      pick = $urandom_range(0, 99);
      q.action = (pick < 38) ? ACT_MOVE : (pick < 75) ? ACT_LOOK :
                 (pick < 93) ? ACT_SCROLL : ACT_NOP;
      q.move_dir = 2'($urandom_range(0, 3));
      q.elapsed = $urandom_range(0, 1) ? 24'($urandom_range(0, 262144)) : 24'($urandom);
      q.offset_x = $urandom_range(0, 2) ? 24'($urandom_range(0, 8192) - 4096) :
                   24'($urandom);
      q.offset_y = $urandom_range(0, 2) ? 24'($urandom_range(0, 8192) - 4096) :
                   24'($urandom);
      q.clamp_pitch = 1'($urandom_range(0, 1));
      return q;
   endfunction

   // Waits at clock edges until every expected vector has been seen.
   task automatic drain();
      while (camera.pending_vectors.size() != 0) @(posedge clock);
   endtask

   // The block must be idle before a register write: drain, then let any
   // request without results finish.
   task automatic write_register(logic [2:0] index, logic [31:0] data);
      req_valid <= 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      camera.write_register(index, data);
   endtask

   task automatic set_world_up(int x, int y, int z);
      write_register(CSR_UPX, 32'(x));
      write_register(CSR_UPY, 32'(y));
      write_register(CSR_UPZ, 32'(z));
   endtask

   task automatic run_random(int count);
      repeat (count) send_request(random_request());
   endtask

   initial begin
      camera = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings: every direction, with elapsed at both
      // extremes and in between, looks at the offset extremes with and without the pitch
      // clamp, scrolls past both zoom limits, and an ignored action.
      send_request(make_request(ACT_MOVE, DIR_FWD, 24'hFFFFFF, 0, 0, 0));
      send_request(make_request(ACT_MOVE, DIR_BACK, 24'd0, 0, 0, 0));
      send_request(make_request(ACT_MOVE, DIR_LEFT, 24'h010000, 0, 0, 0));
      send_request(make_request(ACT_MOVE, DIR_RIGHT, 24'hFFFFFF, 0, 0, 0));
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 24'h7FFFFF, 24'h7FFFFF, 1));
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 24'h800000, 24'h800000, 1));
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 24'h7FFFFF, 24'h7FFFFF, 0));
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 24'h800000, 24'h800000, 0));
      send_request(make_request(ACT_SCROLL, DIR_FWD, 0, 0, 24'h7FFFFF, 0));
      send_request(make_request(ACT_SCROLL, DIR_FWD, 0, 0, 24'h800000, 0));
      send_request(make_request(ACT_NOP, DIR_RIGHT, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 1));
      send_request(make_request(ACT_MOVE, DIR_FWD, 24'h020000, 0, 0, 0));

      // Unit sensitivity: a look can put pitch exactly on a right angle, so
      // forward lines up with world up and the right vector has zero length.
      write_register(CSR_SENS, 32'd256);
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 0, 24'sd5898240, 0));
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 0, -24'sd5898240, 0));
      send_request(make_request(ACT_LOOK, DIR_FWD, 0, 24'sd1000, 24'sd5898240, 1));
      send_request(make_request(ACT_MOVE, DIR_LEFT, 24'h008000, 0, 0, 0));

      // Speed extremes: zero leaves the position alone, full scale saturates.
      write_register(CSR_SPEED, 32'd0);
      send_request(make_request(ACT_MOVE, DIR_FWD, 24'hFFFFFF, 0, 0, 0));
      write_register(CSR_SPEED, 32'hFFFFFFFF);
      send_request(make_request(ACT_MOVE, DIR_RIGHT, 24'hFFFFFF, 0, 0, 0));
      send_request(make_request(ACT_MOVE, DIR_BACK, 24'hFFFFFF, 0, 0, 0));

      // Random phases over several register settings.
      write_register(CSR_SPEED, SPEED_RESET);
      write_register(CSR_SENS, 32'(SENS_RESET));
      run_random(60);

      write_register(CSR_SENS, 32'hFFFF);
      write_register(CSR_SPEED, $urandom);
      set_world_up(65536, -65536, 65536);
      fork
         begin
            long_hold = 1;
         end
         run_random(60);
      join

      write_register(CSR_SENS, 32'd0);
      set_world_up(0, 0, 0);
      run_random(40);

      write_register(CSR_SENS, $urandom_range(1, 65535));
      write_register(CSR_SPEED, $urandom_range(0, 1 << 20));
      set_world_up(-65536, 0, 0);
      run_random(60);

      write_register(CSR_SENS, 32'(SENS_RESET));
      set_world_up($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                   $urandom_range(0, 131072) - 65536);
      run_random(60);

      // Last part without idling on either side.
      set_world_up(0, -65536, 0);
      quiet = 1;
      run_random(70);

      req_valid <= 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d camera events and %0d checked vectors over six register",
               requests_taken, camera.checked);
      $display("settings, including zero speed and sensitivity and a zero world up.");
      if (camera.failures == 0 && camera.pending_vectors.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout waiting for the block");
      $display("status: fail");
      $finish;
   end

endmodule

/* free_fly_camera_update_unit.f */
hdl/ffcu_pkg.sv
hdl/free_fly_camera_update_unit.sv
bench/free_fly_camera_update_unit_tb.sv
